FILE: sv/scaled_font_rect_renderer_assert.svh
// Assertion macros for the scaled font and rectangle renderer.
// Included by the top level; depends on nothing else.
`ifndef SCALED_FONT_RECT_RENDERER_ASSERT_SVH
`define SCALED_FONT_RECT_RENDERER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRF_ASSERT_IMPLIES(name, clk_s, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRF_ASSERT_NEXT(name, clk_s, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/srf_pkg.sv
// Shared types, codes and the 5x7 column font of the renderer.
// No dependencies; imported by the front, the back, the top level and the testbench.
package srf_pkg;

	localparam logic OP_FILL = 1'b0;
	localparam logic OP_CHAR = 1'b1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd2;

	localparam int COORD_W     = 14;
	localparam int CURSOR_W    = 13;
	localparam int CURSOR_MAX  = 4095;
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 7;
	localparam int JOB_DEPTH   = 2;
	localparam int OUT_DEPTH   = 8;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [CURSOR_W-1:0] cursor_t;

	typedef struct packed {
		logic               opcode;
		logic               first_char;
		logic [7:0]         char_code;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic [10:0]        rect_width;
		logic [10:0]        rect_height;
		logic [15:0]        rect_color;
	} item_t;

	typedef struct packed {
		logic        visible;
		logic [7:0]  col_start;
		logic [7:0]  col_end;
		logic [7:0]  row_start;
		logic [7:0]  row_end;
		logic [15:0] pixel_color;
		logic [15:0] pixel_count;
		logic        last_window;
	} result_t;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		logic        is_char;
		coord_t      x;
		coord_t      y;
		logic [10:0] w;
		logic [10:0] h;
		logic [15:0] color;
		logic [7:0]  code;
		logic [3:0]  scale;
	} job_t;

	typedef struct packed {
		logic [15:0] fg;
		logic [15:0] bg;
	} colors_t;

	// Unclipped window as produced by the sequencer.
	typedef struct packed {
		coord_t      x;
		coord_t      y;
		logic [10:0] w;
		logic [10:0] h;
		logic [15:0] color;
		logic        last;
	} win_t;

	// Window after rejection and clipping.
	typedef struct packed {
		logic        vis;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [10:0] w;
		logic [10:0] h;
		logic [15:0] color;
		logic        last;
	} clip_t;

	// Column 0 is leftmost; bit 0 of a column is the top row.
	typedef logic [0:GLYPH_COLS-1][7:0] glyph_t;

	function automatic glyph_t font_glyph(input logic [7:0] code);
		glyph_t g;
		case (code)
			8'h30: g = 40'h3E_51_49_45_3E;
			8'h31: g = 40'h00_42_7F_40_00;
			8'h32: g = 40'h62_51_49_49_46;
			8'h33: g = 40'h22_49_49_49_36;
			8'h34: g = 40'h18_14_12_7F_10;
			8'h35: g = 40'h2F_49_49_49_31;
			8'h36: g = 40'h3E_49_49_49_32;
			8'h37: g = 40'h01_71_09_05_03;
			8'h38: g = 40'h36_49_49_49_36;
			8'h39: g = 40'h26_49_49_49_3E;
			8'h41: g = 40'h7E_11_11_11_7E;
			8'h42: g = 40'h7F_49_49_49_36;
			8'h43: g = 40'h3E_41_41_41_22;
			8'h44: g = 40'h7F_41_41_22_1C;
			8'h45: g = 40'h7F_49_49_49_41;
			8'h46: g = 40'h7F_09_09_09_01;
			8'h47: g = 40'h3E_41_49_49_7A;
			8'h48: g = 40'h7F_08_08_08_7F;
			8'h49: g = 40'h00_41_7F_41_00;
			8'h4A: g = 40'h20_40_41_3F_01;
			8'h4B: g = 40'h7F_08_14_22_41;
			8'h4C: g = 40'h7F_40_40_40_40;
			8'h4D: g = 40'h7F_02_0C_02_7F;
			8'h4E: g = 40'h7F_04_08_10_7F;
			8'h4F: g = 40'h3E_41_41_41_3E;
			8'h50: g = 40'h7F_09_09_09_06;
			8'h51: g = 40'h3E_41_51_21_5E;
			8'h52: g = 40'h7F_09_19_29_46;
			8'h53: g = 40'h46_49_49_49_31;
			8'h54: g = 40'h01_01_7F_01_01;
			8'h55: g = 40'h3F_40_40_40_3F;
			8'h56: g = 40'h1F_20_40_20_1F;
			8'h57: g = 40'h3F_40_38_40_3F;
			8'h58: g = 40'h63_14_08_14_63;
			8'h59: g = 40'h07_08_70_08_07;
			8'h5A: g = 40'h61_51_49_45_43;
			8'h3A: g = 40'h00_36_36_00_00;
			8'h2D: g = 40'h08_08_08_08_08;
			8'h2E: g = 40'h00_60_60_00_00;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

FILE: sv/scaled_font_rect_renderer.sv
// Top level of the scaled font and rectangle renderer.
// Depends on srf_pkg, srf_front, srf_queue, srf_back and the assertion header.
`include "scaled_font_rect_renderer_assert.svh"

// Turns fill and character items into clipped screen windows. A fill item gives
// one window (or a rejection with visible low); a character gives 35 glyph cells
// and one spacer column, and moves the text cursor on by six times the scale. The
// front takes one item per cycle into a two-entry job queue while it is not full;
// the back sequencer produces one window per cycle while the result queue has room
// for it. A window passes through the raw, clip and result stage registers before
// it is pushed. The eight-entry result queue lets input keep flowing while results
// wait to be popped; there is no clearing pass after reset.
module scaled_font_rect_renderer import srf_pkg::*; #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  item_t                item,
	output logic                 empty,
	input  logic                 pop,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	job_t    job_in, job_head;
	logic    job_push, job_pop, job_full, job_empty;
	logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
	colors_t colors;
	logic    out_push, out_full;
	result_t out_result;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

	assign full = job_full;

	srf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (push),
		.item       (item),
		.job_full   (job_full),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg_ready  (cfg_ready),
		.job_push   (job_push),
		.job        (job_in),
		.colors     (colors)
	);

	srf_queue #(
		.WIDTH ($bits(job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.pop    (job_pop),
		.rdata  (job_head),
		.full   (job_full),
		.empty  (job_empty),
		.count  (job_count)
	);

	srf_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_empty  (job_empty),
		.job        (job_head),
		.job_pop    (job_pop),
		.colors     (colors),
		.out_count  (out_count),
		.out_push   (out_push),
		.out_result (out_result)
	);

	srf_queue #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_result),
		.pop    (pop),
		.rdata  (result),
		.full   (out_full),
		.empty  (empty),
		.count  (out_count)
	);

	`SRF_ASSERT_IMPLIES(a_out_no_overflow, clk, arst_n, out_push, !out_full, "result queue overflow")
	`SRF_ASSERT_IMPLIES(a_job_pop_ok, clk, arst_n, job_pop, job_count != '0, "job popped from empty queue")
	`SRF_ASSERT_NEXT(a_job_lands, clk, arst_n, push && !full, job_count != '0, "accepted item lost")
	`SRF_ASSERT_IMPLIES(a_reject_zero, clk, arst_n, !empty && !result.visible, result.pixel_count == 16'd0 && result.col_end == 8'd0 && result.pixel_color == 16'd0, "rejected window not zeroed")

endmodule

FILE: sv/srf_queue.sv
// Small first-in first-out queue used between the stages of the renderer.
// Stand-alone; no package dependency.
module srf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = store_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: sv/srf_front.sv
// Front end: configuration registers, text cursor and item classification.
// Depends on srf_pkg; feeds the job queue read by srf_back.
module srf_front import srf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  item_t                item,
	input  logic                 job_full,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output logic                 cfg_ready,
	output logic                 job_push,
	output job_t                 job,
	output colors_t              colors
);

	logic [15:0] fg_q, bg_q;
	logic [3:0]  scale_q;
	cursor_t     cursor_q;

	logic        accept;
	logic [3:0]  scale_eff;
	logic [6:0]  step6;
	cursor_t     start_x;
	coord_t      advanced;
	logic        is_char;

	assign cfg_ready = 1'b1;
	assign accept    = item_valid & ~job_full;
	assign job_push  = accept;
	assign is_char   = (item.opcode == OP_CHAR);
	assign scale_eff = (scale_q == 4'd0) ? 4'd1 : scale_q;
	assign step6     = 7'({scale_eff, 2'b00}) + 7'({scale_eff, 1'b0});
	assign start_x   = item.first_char ? cursor_t'(item.pos_x) : cursor_q;
	assign advanced  = coord_t'(start_x) + coord_t'(step6);
	assign colors    = '{fg: fg_q, bg: bg_q};

	always_comb begin
		job.is_char = is_char;
		job.x       = is_char ? coord_t'(start_x) : coord_t'(item.pos_x);
		job.y       = coord_t'(item.pos_y);
		job.w       = item.rect_width;
		job.h       = item.rect_height;
		job.color   = item.rect_color;
		job.code    = item.char_code;
		job.scale   = scale_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q     <= 16'hFFFF;
			bg_q     <= 16'h0000;
			scale_q  <= 4'd1;
			cursor_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_FOREGROUND: fg_q <= cfg_data;
					CFG_BACKGROUND: bg_q <= cfg_data;
					CFG_SCALE:      scale_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			// The cursor moves on as soon as a character is accepted.
			if (accept && is_char) begin
				cursor_q <= (advanced > coord_t'(CURSOR_MAX)) ?
					cursor_t'(CURSOR_MAX) : cursor_t'(advanced);
			end
		end
	end

endmodule

FILE: sv/srf_back.sv
// Back end: expands jobs into windows, then rejects, clips and sizes them.
// Depends on srf_pkg; reads the job queue and writes the result queue.
module srf_back import srf_pkg::*; #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_empty,
	input  job_t                           job,
	output logic                           job_pop,
	input  colors_t                        colors,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                           out_push,
	output result_t                        out_result
);

	localparam coord_t SW_C = coord_t'(SCREEN_WIDTH);
	localparam coord_t SH_C = coord_t'(SCREEN_HEIGHT);
	localparam int CREDIT_W = $clog2(OUT_DEPTH + 1) + 1;

	// Sequencer state for a character in progress.
	logic       busy_q;
	logic [2:0] col_q, row_q;
	coord_t     xc_q, yc_q, base_y_q;
	logic [3:0] scale_q;
	logic [7:0] code_q;

	logic [2:0]  cur_col, cur_row, glyph_col;
	coord_t      cur_x, cur_y, cur_base_y;
	logic [3:0]  cur_s;
	logic [7:0]  cur_code;
	logic        is_char, spacer, pix_on, fire, credit_ok;
	glyph_t      glyph;
	logic [7:0]  col_bits;
	logic [10:0] s_w, s7;
	win_t        raw;
	logic [CREDIT_W-1:0] in_flight;

	logic    v_s1, v_s2, v_s3;
	win_t    win_s1;
	clip_t   clip_s2;
	result_t res_s3;

	// A window may start only if the result queue has room for it and
	// everything already in the clip pipeline.
	assign in_flight = CREDIT_W'(out_count) + CREDIT_W'(v_s1) + CREDIT_W'(v_s2)
		+ CREDIT_W'(v_s3);
	assign credit_ok = (in_flight < CREDIT_W'(OUT_DEPTH));
	assign fire      = credit_ok & (busy_q | ~job_empty);
	assign job_pop   = fire & ~busy_q;

	assign cur_col    = busy_q ? col_q : 3'd0;
	assign cur_row    = busy_q ? row_q : 3'd0;
	assign cur_x      = busy_q ? xc_q : job.x;
	assign cur_y      = busy_q ? yc_q : job.y;
	assign cur_base_y = busy_q ? base_y_q : job.y;
	assign cur_s      = busy_q ? scale_q : job.scale;
	assign cur_code   = busy_q ? code_q : job.code;
	assign is_char    = busy_q | job.is_char;
	assign spacer     = (cur_col == 3'(GLYPH_COLS));

	assign glyph     = font_glyph(cur_code);
	assign glyph_col = spacer ? 3'd0 : cur_col;
	assign col_bits  = glyph[glyph_col];
	assign pix_on    = col_bits[cur_row];
	assign s_w       = 11'(cur_s);
	assign s7        = 11'({cur_s, 3'b000}) - 11'(cur_s);

	always_comb begin
		if (!is_char) begin
			raw = '{x: job.x, y: job.y, w: job.w, h: job.h, color: job.color, last: 1'b1};
		end else if (spacer) begin
			raw = '{x: cur_x, y: cur_base_y, w: s_w, h: s7, color: colors.bg, last: 1'b1};
		end else begin
			raw = '{x: cur_x, y: cur_y, w: s_w, h: s_w,
				color: pix_on ? colors.fg : colors.bg, last: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			v_s1 <= fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (fire) begin
				busy_q <= is_char & ~spacer;
			end
		end
	end

	// Cells go down a column, then the next column starts at the top row.
	always_ff @(posedge clk) begin
		if (fire) begin
			scale_q  <= cur_s;
			code_q   <= cur_code;
			base_y_q <= cur_base_y;
			if (cur_row == 3'(GLYPH_ROWS - 1)) begin
				col_q <= cur_col + 3'd1;
				row_q <= 3'd0;
				xc_q  <= cur_x + coord_t'(cur_s);
				yc_q  <= cur_base_y;
			end else begin
				col_q <= cur_col;
				row_q <= cur_row + 3'd1;
				xc_q  <= cur_x;
				yc_q  <= cur_y + coord_t'(cur_s);
			end
		end
	end

	// Stage 1 holds the raw window.
	always_ff @(posedge clk) begin
		win_s1 <= raw;
	end

	// Stage 2: rejection and clipping against the right and bottom edges.
	logic   reject;
	coord_t room_x, room_y;
	always_comb begin
		reject = (win_s1.x < 0) || (win_s1.y < 0) || (win_s1.w == '0) || (win_s1.h == '0)
			|| (win_s1.x >= SW_C) || (win_s1.y >= SH_C);
		room_x = SW_C - win_s1.x;
		room_y = SH_C - win_s1.y;
	end

	always_ff @(posedge clk) begin
		clip_s2.vis   <= ~reject;
		clip_s2.x     <= win_s1.x[7:0];
		clip_s2.y     <= win_s1.y[7:0];
		clip_s2.w     <= (coord_t'(win_s1.w) > room_x) ? room_x[10:0] : win_s1.w;
		clip_s2.h     <= (coord_t'(win_s1.h) > room_y) ? room_y[10:0] : win_s1.h;
		clip_s2.color <= win_s1.color;
		clip_s2.last  <= win_s1.last;
	end

	// Stage 3: area, inclusive end coordinates and zeroing of rejections.
	logic [21:0] area;
	assign area = 22'(clip_s2.w) * 22'(clip_s2.h);

	always_ff @(posedge clk) begin
		res_s3.last_window <= clip_s2.last;
		if (clip_s2.vis) begin
			res_s3.visible     <= 1'b1;
			res_s3.col_start   <= clip_s2.x;
			res_s3.col_end     <= 8'(clip_s2.x + clip_s2.w[7:0] - 8'd1);
			res_s3.row_start   <= clip_s2.y;
			res_s3.row_end     <= 8'(clip_s2.y + clip_s2.h[7:0] - 8'd1);
			res_s3.pixel_color <= clip_s2.color;
			res_s3.pixel_count <= (|area[21:16]) ? 16'hFFFF : area[15:0];
		end else begin
			res_s3.visible     <= 1'b0;
			res_s3.col_start   <= '0;
			res_s3.col_end     <= '0;
			res_s3.row_start   <= '0;
			res_s3.row_end     <= '0;
			res_s3.pixel_color <= '0;
			res_s3.pixel_count <= '0;
		end
	end

	assign out_push   = v_s3;
	assign out_result = res_s3;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for scaled_font_rect_renderer: fill and character items in,
// clipped windows out, each window checked against an in-bench predictor.
// Depends on srf_pkg and the renderer RTL only.
`timescale 1ns / 1ps

module testbench;
	import srf_pkg::*;

	localparam int SCREEN_W       = 240;
	localparam int SCREEN_H       = 240;
	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic                 full;
	item_t                item      = '0;
	logic                 empty;
	logic                 pop       = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_FOREGROUND;
	logic [15:0]          cfg_data  = '0;

	// Predictor state: register copies and the text cursor.
	logic [15:0] fg_colour  = 16'hFFFF;
	logic [15:0] bg_colour  = 16'h0000;
	logic [3:0]  glyph_size = 4'd1;
	int          text_col   = 0;

	result_t expected_windows[$];
	int      mismatches     = 0;
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;
	int      hold_left      = 0;
	int      idle_cycles    = 0;

	// Column font: column 0 in the top byte, bit 0 of a column is the top row.
	logic [39:0] digit_font [10] = '{
		40'h3E5149453E, 40'h00427F4000, 40'h6251494946, 40'h2249494936,
		40'h1814127F10, 40'h2F49494931, 40'h3E49494932, 40'h0171090503,
		40'h3649494936, 40'h264949493E
	};
	logic [39:0] capital_font [26] = '{
		40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
		40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
		40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
		40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
		40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
		40'h0708700807, 40'h6151494543
	};

	scaled_font_rect_renderer #(
		.SCREEN_WIDTH (SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] glyph_column(logic [7:0] code, int col);
		logic [39:0] g;
		g = '0;
		if (code >= 8'h30 && code <= 8'h39) begin
			g = digit_font[code - 8'h30];
		end else if (code >= 8'h41 && code <= 8'h5A) begin
			g = capital_font[code - 8'h41];
		end else if (code == 8'h3A) begin
			g = 40'h0036360000;
		end else if (code == 8'h2D) begin
			g = 40'h0808080808;
		end else if (code == 8'h2E) begin
			g = 40'h0060600000;
		end
		return g[39 - 8 * col -: 8];
	endfunction

	// Rejects or clips one window against the screen.
	function automatic result_t clip_window(int x, int y, int w, int h,
			logic [15:0] colour, bit last);
		result_t r;
		int      n;
		r = '0;
		r.last_window = last;
		if (x < 0 || y < 0 || w <= 0 || h <= 0 || x >= SCREEN_W || y >= SCREEN_H)
			return r;
		if (w > SCREEN_W - x)
			w = SCREEN_W - x;
		if (h > SCREEN_H - y)
			h = SCREEN_H - y;
		n = w * h;
		r.visible     = 1'b1;
		r.col_start   = x[7:0];
		r.col_end     = 8'(x + w - 1);
		r.row_start   = y[7:0];
		r.row_end     = 8'(y + h - 1);
		r.pixel_color = colour;
		r.pixel_count = (n > 65535) ? 16'hFFFF : n[15:0];
		return r;
	endfunction

	// Appends every window that one accepted item produces.
	function automatic void render_windows(item_t it);
		int          px, py, s, cx;
		logic [7:0]  bits;
		px = $signed(it.pos_x);
		py = $signed(it.pos_y);
		if (it.opcode == OP_FILL) begin
			expected_windows.push_back(clip_window(px, py, int'(it.rect_width),
				int'(it.rect_height), it.rect_color, 1'b1));
			return;
		end
		if (it.first_char)
			text_col = px;
		s  = (glyph_size == 4'd0) ? 1 : int'(glyph_size);
		cx = text_col;
		for (int col = 0; col < 5; col++) begin
			bits = glyph_column(it.char_code, col);
			for (int row = 0; row < 7; row++)
				expected_windows.push_back(clip_window(cx + col * s, py + row * s, s, s,
					bits[row] ? fg_colour : bg_colour, 1'b0));
		end
		expected_windows.push_back(clip_window(cx + 5 * s, py, s, 7 * s, bg_colour, 1'b1));
		text_col = (cx + 6 * s > CURSOR_MAX) ? CURSOR_MAX : cx + 6 * s;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Every result transfer is compared with the oldest predicted window.
	always @(posedge clk) begin : check_windows
		result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_windows.size() == 0) begin
				$error("window transfer with nothing predicted: %h", result);
				mismatches++;
			end else begin
				want = expected_windows.pop_front();
				check_field("visible", want.visible, result.visible);
				check_field("col_start", want.col_start, result.col_start);
				check_field("col_end", want.col_end, result.col_end);
				check_field("row_start", want.row_start, result.row_start);
				check_field("row_end", want.row_end, result.row_end);
				check_field("pixel_color", want.pixel_color, result.pixel_color);
				check_field("pixel_count", want.pixel_count, result.pixel_count);
				check_field("last_window", want.last_window, result.last_window);
			end
		end
	end

	// Result side: a long hold-off when requested, otherwise random stalls.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left--;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_item(input item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		render_windows(it);
	endtask

	// Stops sending and lets every predicted window drain out of the block.
	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (expected_windows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FOREGROUND: fg_colour  = data;
			CFG_BACKGROUND: bg_colour  = data;
			CFG_SCALE:      glyph_size = data[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_text_style(input logic [15:0] fg, input logic [15:0] bg,
			input logic [15:0] scale_word);
		write_reg(CFG_FOREGROUND, fg);
		write_reg(CFG_BACKGROUND, bg);
		write_reg(CFG_SCALE, scale_word);
	endtask

	function automatic item_t random_item();
		item_t it;
		it.opcode      = 1'($urandom);
		it.first_char  = 1'($urandom);
		it.char_code   = 8'($urandom);
		it.pos_x       = 12'(($urandom_range(99) < 70) ? $urandom_range(0, 279) - 20 : $urandom);
		it.pos_y       = 12'(($urandom_range(99) < 70) ? $urandom_range(0, 279) - 20 : $urandom);
		it.rect_width  = 11'(($urandom_range(99) < 70) ? $urandom_range(0, 260) : $urandom);
		it.rect_height = 11'(($urandom_range(99) < 70) ? $urandom_range(0, 260) : $urandom);
		it.rect_color  = 16'($urandom);
		return it;
	endfunction

	function automatic item_t fill_item(int x, int y, int w, int h, logic [15:0] colour);
		item_t it;
		it             = random_item();
		it.opcode      = OP_FILL;
		it.pos_x       = 12'(x);
		it.pos_y       = 12'(y);
		it.rect_width  = 11'(w);
		it.rect_height = 11'(h);
		it.rect_color  = colour;
		return it;
	endfunction

	function automatic item_t char_item(logic [7:0] code, bit first, int x, int y);
		item_t it;
		it            = random_item();
		it.opcode     = OP_CHAR;
		it.first_char = first;
		it.char_code  = code;
		it.pos_x      = 12'(x);
		it.pos_y      = 12'(y);
		return it;
	endfunction

	// Maps 0..39 onto the codes that have a glyph, with space last.
	function automatic logic [7:0] glyph_code(int idx);
		if (idx < 10)
			return 8'(8'h30 + idx);
		if (idx < 36)
			return 8'(8'h41 + idx - 10);
		case (idx)
			36:      return 8'h3A;
			37:      return 8'h2D;
			38:      return 8'h2E;
			default: return 8'h20;
		endcase
	endfunction

	task automatic test_directed_windows();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_item(fill_item(0, 0, 240, 240, 16'hFFFF));
		send_item(fill_item(0, 0, 2047, 2047, 16'h0000));
		send_item(fill_item(10, 10, 0, 5, 16'h1234));
		send_item(fill_item(10, 10, 5, 0, 16'h1234));
		send_item(fill_item(-1, 0, 10, 10, 16'h5555));
		send_item(fill_item(0, -2048, 10, 10, 16'hAAAA));
		send_item(fill_item(239, 239, 1, 1, 16'h00FF));
		send_item(fill_item(240, 0, 1, 1, 16'hFF00));
		send_item(fill_item(0, 240, 1, 1, 16'hFF00));
		send_item(fill_item(2047, 2047, 2047, 2047, 16'hFFFF));
		send_item(fill_item(200, 100, 100, 30, 16'hBEEF));
		// A line of text across every glyph group, then codes without a glyph.
		send_item(char_item(8'h30, 1'b1, 0, 0));
		send_item(char_item(8'h41, 1'b0, 0, 0));
		send_item(char_item(8'h5A, 1'b0, 0, 0));
		send_item(char_item(8'h3A, 1'b0, 0, 0));
		send_item(char_item(8'h2D, 1'b0, 0, 0));
		send_item(char_item(8'h2E, 1'b0, 0, 0));
		send_item(char_item(8'h20, 1'b0, 0, 0));
		send_item(char_item(8'hFF, 1'b0, 0, 0));
		send_item(char_item(8'h61, 1'b0, 0, 0));
		// Negative cursor, a glyph cut by both screen edges, and one entirely off screen.
		send_item(char_item(8'h39, 1'b1, -4, 10));
		send_item(char_item(8'h4D, 1'b1, 236, 236));
		send_item(char_item(8'h57, 1'b1, 2047, 2047));
		wait_idle();
	endtask

	// Mostly well-formed text lines with fills in between; the rest is noise.
	task automatic test_random_traffic(int count, int send_idle, int recv_stall,
			bit saturate_cursor);
		item_t it;
		int    line_left;
		int    line_y;
		send_idle_pct  = send_idle;
		recv_stall_pct = recv_stall;
		line_left      = 0;
		line_y         = 0;
		for (int i = 0; i < count; i++) begin
			it = random_item();
			if ($urandom_range(99) < 35) begin
				it.opcode = OP_FILL;
			end else begin
				it.opcode = OP_CHAR;
				if ($urandom_range(99) < 90) begin
					it.char_code  = glyph_code($urandom_range(39));
					it.first_char = (line_left == 0);
					if (line_left == 0) begin
						line_left = $urandom_range(1, 10);
						line_y    = $signed(it.pos_y);
						if (saturate_cursor) begin
							// Long enough at the largest size to drive the cursor into its limit.
							line_left       = 26;
							it.pos_x        = 12'(2047 - $urandom_range(0, 100));
							saturate_cursor = 1'b0;
						end
					end
					it.pos_y = 12'(line_y);
					line_left--;
				end
			end
			send_item(it);
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_item(char_item(8'h42, 1'b1, 4, 4));
		// Results are held back while character items keep arriving, so the input stalls.
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 14; i++)
			send_item(char_item(glyph_code($urandom_range(39)), 1'b0, 0, 4));
		wait_idle();
		recv_stall_pct = 25;
		for (int i = 0; i < 8; i++)
			send_item(random_item());
		wait_idle();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_windows();

		set_text_style(16'h0000, 16'hFFFF, 16'(($urandom << 4) | 0));
		test_random_traffic(95, 0, 0, 1'b0);

		set_text_style(16'($urandom), 16'($urandom), 16'(($urandom << 4) | 2));
		test_random_traffic(95, 77, 0, 1'b0);

		set_text_style(16'hFFFF, 16'h0000, 16'(($urandom << 4) | 15));
		test_random_traffic(95, 0, 77, 1'b1);

		set_text_style(16'($urandom), 16'($urandom), 16'($urandom));
		test_random_traffic(95, 25, 25, 1'b0);

		set_text_style(16'($urandom), 16'($urandom), 16'(($urandom << 4) | 1));
		test_backpressure();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/srf_pkg.sv
sv/srf_queue.sv
sv/srf_front.sv
sv/srf_back.sv
sv/scaled_font_rect_renderer.sv
tb/testbench.sv
